// ----- sv/pa_pkg.sv -----
// Package for the Pareto archive insert core: widths, codes and shared types.
// No dependencies; imported by pa_lane, pa_dist and the core, not by pa_ram.
`default_nettype none
package pa_pkg;

    localparam int OBJ_W     = 32;   // signed Q16.16 objective
    localparam int TAG_W     = 16;
    localparam int DIV_W     = 31;   // stored maxima are never negative
    localparam int RATIO_W   = 16;   // unsigned Q8.8 ratio
    localparam int TERM_W    = 2 * RATIO_W;
    localparam int DIST_W    = 36;
    localparam int DIV_STEPS = 2;    // quotient bits per cycle
    localparam int DIV_CYC   = RATIO_W / DIV_STEPS;
    localparam int CNT_W     = $clog2(DIV_CYC);

    localparam logic [DIST_W-1:0] DIST_INF = {DIST_W{1'b1}};

    localparam int OUTCOME_W = 3;
    localparam int SLOT_W    = 6;
    localparam int OCC_W     = 7;
    localparam int NOBJ_W    = 3;
    localparam int CAP_W     = 7;

    localparam logic CFG_OBJECTIVES = 1'b0;
    localparam logic CFG_CAPACITY   = 1'b1;

    typedef enum logic [OUTCOME_W-1:0] {
        OC_REPLACED_DOM   = 3'd0,
        OC_REJECTED_DOM   = 3'd1,
        OC_APPENDED       = 3'd2,
        OC_REPLACED_CROWD = 3'd3,
        OC_REJECTED_CROWD = 3'd4,
        OC_MAXIMA         = 3'd5
    } t_outcome;

    // lane result toward the merging stage
    typedef struct packed {
        logic              done;
        logic [TERM_W-1:0] term;
    } t_lane_res;

endpackage
`default_nettype wire

// ----- sv/pa_ram.sv -----
// Generic RAM: one write port, two read ports, registered read data.
// No dependencies.
`default_nettype none
module pa_ram #(
    parameter int WIDTH = 144,
    parameter int DEPTH = 64
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr_a,
    output logic      [WIDTH-1:0]         o_rdata_a,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr_b,
    output logic      [WIDTH-1:0]         o_rdata_b
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata_a <= r_mem[i_raddr_a];
        o_rdata_b <= r_mem[i_raddr_b];
    end
endmodule
`default_nettype wire

// ----- sv/pa_lane.sv -----
// One objective lane: |a-b|*256/div saturated to 16 bits, then squared.
// Uses pa_pkg. Radix-4 restoring divider, fixed latency.
`default_nettype none
module pa_lane (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire logic                      i_start,
    input  wire logic                      i_en,
    input  wire logic [pa_pkg::OBJ_W-1:0]  i_a,
    input  wire logic [pa_pkg::OBJ_W-1:0]  i_b,
    input  wire logic [pa_pkg::DIV_W-1:0]  i_div,
    output pa_pkg::t_lane_res              o_res
);
    import pa_pkg::*;

    logic [OBJ_W:0]       diff;
    logic [OBJ_W:0]       ad;
    logic                 sat;
    logic                 r_busy, r_sq, r_done, r_sat, r_en;
    logic [CNT_W-1:0]     r_cnt;
    logic [DIV_W-1:0]     r_rem, r_div, n_rem;
    logic [RATIO_W-1:0]   r_low, r_q, n_low, n_q, ratio;
    logic [TERM_W-1:0]    r_term;
    logic [DIV_W:0]       t;

    always_comb begin
        diff = {i_a[OBJ_W-1], i_a} - {i_b[OBJ_W-1], i_b};
        ad   = diff[OBJ_W] ? (~diff + 1'b1) : diff;
        sat  = {6'd0, ad} >= {i_div, 8'd0};
    end

    always_comb begin
        n_rem = r_rem;
        n_low = r_low;
        n_q   = r_q;
        t     = '0;
        for (int s = 0; s < DIV_STEPS; s++) begin
            t     = {n_rem, n_low[RATIO_W-1]};
            n_low = {n_low[RATIO_W-2:0], 1'b0};
            if (t >= {1'b0, r_div}) begin
                n_rem = DIV_W'(t - {1'b0, r_div});
                n_q   = {n_q[RATIO_W-2:0], 1'b1};
            end else begin
                n_rem = t[DIV_W-1:0];
                n_q   = {n_q[RATIO_W-2:0], 1'b0};
            end
        end
        ratio = r_sat ? {RATIO_W{1'b1}} : r_q;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_sq   <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
                r_sat  <= sat;
                r_en   <= i_en;
                r_div  <= i_div;
                r_rem  <= DIV_W'(ad[OBJ_W:8]);
                r_low  <= {ad[7:0], 8'd0};
                r_q    <= '0;
            end else if (r_busy) begin
                r_rem <= n_rem;
                r_low <= n_low;
                r_q   <= n_q;
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == CNT_W'(DIV_CYC - 1)) begin
                    r_busy <= 1'b0;
                    r_sq   <= 1'b1;
                end
            end else if (r_sq) begin
                r_sq   <= 1'b0;
                r_done <= 1'b1;
                r_term <= r_en ? ratio * ratio : '0;
            end
        end
    end

    assign o_res.done = r_done;
    assign o_res.term = r_term;
endmodule
`default_nettype wire

// ----- sv/pa_dist.sv -----
// Normalized squared distance: objective lanes side by side, summed in a merge stage.
// Uses pa_pkg and pa_lane.
`default_nettype none
module pa_dist #(
    parameter int MAX_OBJECTIVES = 4
) (
    input  wire logic                                      i_clk,
    input  wire logic                                      i_rst_n,
    input  wire logic                                      i_start,
    input  wire logic [MAX_OBJECTIVES-1:0]                 i_en,
    input  wire logic [MAX_OBJECTIVES*pa_pkg::OBJ_W-1:0]   i_a,
    input  wire logic [MAX_OBJECTIVES*pa_pkg::OBJ_W-1:0]   i_b,
    input  wire logic [MAX_OBJECTIVES*pa_pkg::DIV_W-1:0]   i_div,
    output logic                                           o_done,
    output logic      [pa_pkg::DIST_W-1:0]                 o_dist
);
    import pa_pkg::*;

    t_lane_res         lane_res [MAX_OBJECTIVES];
    logic [DIST_W-1:0] sum;

    for (genvar k = 0; k < MAX_OBJECTIVES; k++) begin : g_lane
        pa_lane u_lane (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_start (i_start),
            .i_en    (i_en[k]),
            .i_a     (i_a[k*OBJ_W +: OBJ_W]),
            .i_b     (i_b[k*OBJ_W +: OBJ_W]),
            .i_div   (i_div[k*DIV_W +: DIV_W]),
            .o_res   (lane_res[k])
        );
    end

    always_comb begin
        sum = '0;
        for (int k = 0; k < MAX_OBJECTIVES; k++) begin
            sum = sum + DIST_W'(lane_res[k].term);
        end
    end

    // all lanes share one latency
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_done <= 1'b0;
        end else begin
            o_done <= lane_res[0].done;
        end
        o_dist <= sum;
    end
endmodule
`default_nettype wire

// ----- sv/pareto_archive_insert_core.sv -----
// Pareto archive insert core: maxima update, dominance scan, append, crowding replacement.
// Uses pa_pkg, pa_ram (entry store) and pa_dist (objective lanes + merge).
//
//  channel   dir  handshake                  payload
//  s_axis    in   s_axis_tvalid/tready       tdata {obj_3..obj_0, entry_tag}, tuser kind
//  m_axis    out  m_axis_tvalid/tready       tdata {occupancy, slot, outcome}
//  cfg       in   i_cfg_we                   i_cfg_addr, i_cfg_wdata
//
// Flow: a maxima item goes from idle straight to done. An offer scans the held entries N,
// a read state and a check state each, then decides. A full archive then runs
// crowding over N*N pairs, paced by the lane divider (2 quotient bits per cycle).
// Reset: synchronous, active low; clears count, maxima, config, output valid.
// Entry store has no reset. A waiting result sits in the output register;
// the next item is taken meanwhile and waits only for that register at its end.
`default_nettype none
module pareto_archive_insert_core #(
    parameter int ARCHIVE_DEPTH  = 64,
    parameter int MAX_OBJECTIVES = 4
) (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    // offer / maxima items
    input  wire logic                   s_axis_tvalid,
    output logic                        s_axis_tready,
    input  wire logic [143:0]           s_axis_tdata,  // entry_tag, obj_0, obj_1, obj_2, obj_3
    input  wire logic                   s_axis_tuser,  // kind
    // result items
    output logic                        m_axis_tvalid,
    input  wire logic                   m_axis_tready,
    output logic      [15:0]            m_axis_tdata,  // outcome, slot, occupancy
    // configuration
    input  wire logic                   i_cfg_we,
    input  wire logic                   i_cfg_addr,
    input  wire logic [pa_pkg::CAP_W-1:0] i_cfg_wdata
);
    import pa_pkg::*;

    localparam int AW     = $clog2(ARCHIVE_DEPTH);
    localparam int CW     = $clog2(ARCHIVE_DEPTH + 1);
    localparam int WORD_W = MAX_OBJECTIVES * OBJ_W + TAG_W;

    typedef enum logic [8:0] {
        S_IDLE     = 9'b000000001,
        S_SCAN_RD  = 9'b000000010,
        S_SCAN_CHK = 9'b000000100,
        S_DECIDE   = 9'b000001000,
        S_CR_RD    = 9'b000010000,
        S_CR_LD    = 9'b000100000,
        S_CR_WAIT  = 9'b001000000,
        S_CR_END   = 9'b010000000,
        S_DONE     = 9'b100000000
    } t_state;

    t_state                         r_state;
    logic [NOBJ_W-1:0]              r_nobj;
    logic [CAP_W-1:0]               r_cap;
    logic [CW-1:0]                  r_count;
    logic signed [OBJ_W-1:0]        r_max [MAX_OBJECTIVES];
    logic [MAX_OBJECTIVES*OBJ_W-1:0] r_v;
    logic [TAG_W-1:0]               r_tag;
    logic [AW-1:0]                  r_i, r_j, r_at;
    logic [DIST_W-1:0]              r_own, r_nn, r_mn, n_own, n_nn;
    t_outcome                       r_res_oc;
    logic [AW-1:0]                  r_res_slot;
    logic                           r_out_valid;
    logic [15:0]                    r_out_data;

    logic [NOBJ_W-1:0]              n_eff;
    logic [MAX_OBJECTIVES-1:0]      en;
    logic [CW-1:0]                  cap_eff;
    logic [MAX_OBJECTIVES*DIV_W-1:0] div;
    logic [WORD_W-1:0]              rd_a, rd_b;
    logic                           ram_we;
    logic [AW-1:0]                  ram_waddr;
    logic                           dom_ve, dom_ev;
    logic                           last_i, last_j, room, out_free, take, crowd_win;
    logic                           dist_start, dist_done;
    logic [DIST_W-1:0]              pair_dist;
    logic [MAX_OBJECTIVES*OBJ_W-1:0] op_a;

    // effective config, clamped into range
    always_comb begin
        if (r_nobj == '0) begin
            n_eff = NOBJ_W'(1);
        end else if (r_nobj > NOBJ_W'(MAX_OBJECTIVES)) begin
            n_eff = NOBJ_W'(MAX_OBJECTIVES);
        end else begin
            n_eff = r_nobj;
        end
        if (r_cap == '0) begin
            cap_eff = CW'(1);
        end else if ({25'd0, r_cap} > 32'(ARCHIVE_DEPTH)) begin
            cap_eff = CW'(ARCHIVE_DEPTH);
        end else begin
            cap_eff = CW'(r_cap);
        end
        for (int k = 0; k < MAX_OBJECTIVES; k++) begin
            en[k] = 32'(k) < {29'd0, n_eff};
            // divisor floored at one LSB; maxima never go negative
            div[k*DIV_W +: DIV_W] = (r_max[k] == '0) ? DIV_W'(1) : r_max[k][DIV_W-1:0];
        end
    end

    // dominance lanes against the entry on read port A
    always_comb begin
        logic le_all, ge_all, ne_any;
        logic signed [OBJ_W-1:0] va, ea;
        le_all = 1'b1;
        ge_all = 1'b1;
        ne_any = 1'b0;
        for (int k = 0; k < MAX_OBJECTIVES; k++) begin
            va = r_v[k*OBJ_W +: OBJ_W];
            ea = rd_a[k*OBJ_W +: OBJ_W];
            if (en[k]) begin
                le_all = le_all & (va <= ea);
                ge_all = ge_all & (va >= ea);
                ne_any = ne_any | (va != ea);
            end
        end
        dom_ve = le_all & ne_any;
        dom_ev = ge_all & ne_any;
    end

    assign last_i    = CW'(r_i) == (r_count - CW'(1));
    assign last_j    = CW'(r_j) == (r_count - CW'(1));
    assign room      = r_count < cap_eff;
    assign crowd_win = r_own > r_mn;
    assign out_free  = !r_out_valid || m_axis_tready;
    assign take      = s_axis_tvalid && s_axis_tready;

    // diagonal pair measures the offer against entry i instead
    assign op_a       = (r_i == r_j) ? r_v : rd_b[MAX_OBJECTIVES*OBJ_W-1:0];
    assign dist_start = (r_state == S_CR_LD);

    always_comb begin
        n_own = r_own;
        n_nn  = r_nn;
        if (r_i == r_j) begin
            if (pair_dist < r_own) n_own = pair_dist;
        end else begin
            if (pair_dist < r_nn) n_nn = pair_dist;
        end
    end

    always_comb begin
        ram_we    = 1'b0;
        ram_waddr = r_i;
        unique case (r_state)
            S_SCAN_CHK: ram_we = dom_ve;
            S_DECIDE: begin
                ram_we    = room;
                ram_waddr = AW'(r_count);
            end
            S_CR_END: begin
                ram_we    = crowd_win;
                ram_waddr = r_at;
            end
            default: ram_we = 1'b0;
        endcase
    end

    pa_ram #(
        .WIDTH (WORD_W),
        .DEPTH (ARCHIVE_DEPTH)
    ) u_ram (
        .i_clk     (i_clk),
        .i_we      (ram_we),
        .i_waddr   (ram_waddr),
        .i_wdata   ({r_tag, r_v}),
        .i_raddr_a (r_i),
        .o_rdata_a (rd_a),
        .i_raddr_b (r_j),
        .o_rdata_b (rd_b)
    );

    pa_dist #(
        .MAX_OBJECTIVES (MAX_OBJECTIVES)
    ) u_dist (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (dist_start),
        .i_en    (en),
        .i_a     (op_a),
        .i_b     (rd_a[MAX_OBJECTIVES*OBJ_W-1:0]),
        .i_div   (div),
        .o_done  (dist_done),
        .o_dist  (pair_dist)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_nobj      <= NOBJ_W'(2);
            r_cap       <= CAP_W'(64);
            r_count     <= '0;
            r_out_valid <= 1'b0;
            for (int k = 0; k < MAX_OBJECTIVES; k++) r_max[k] <= '0;
        end else begin
            if (i_cfg_we) begin
                if (i_cfg_addr == CFG_OBJECTIVES) begin
                    r_nobj <= i_cfg_wdata[NOBJ_W-1:0];
                end else begin
                    r_cap <= i_cfg_wdata;
                end
            end

            if (r_state == S_DONE && out_free) begin
                r_out_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end

            unique case (r_state)
                S_IDLE: begin
                    if (take) begin
                        r_i <= '0;
                        r_j <= '0;
                        if (s_axis_tuser) begin
                            for (int k = 0; k < MAX_OBJECTIVES; k++) begin
                                if (en[k] && $signed(s_axis_tdata[TAG_W+k*OBJ_W +: OBJ_W])
                                        > r_max[k]) begin
                                    r_max[k] <= s_axis_tdata[TAG_W+k*OBJ_W +: OBJ_W];
                                end
                            end
                            r_res_oc   <= OC_MAXIMA;
                            r_res_slot <= '0;
                            r_state    <= S_DONE;
                        end else if (r_count == '0) begin
                            r_state <= S_DECIDE;
                        end else begin
                            r_state <= S_SCAN_RD;
                        end
                    end
                end
                S_SCAN_RD: r_state <= S_SCAN_CHK;
                S_SCAN_CHK: begin
                    if (dom_ve) begin
                        r_res_oc   <= OC_REPLACED_DOM;
                        r_res_slot <= r_i;
                        r_state    <= S_DONE;
                    end else if (dom_ev) begin
                        r_res_oc   <= OC_REJECTED_DOM;
                        r_res_slot <= r_i;
                        r_state    <= S_DONE;
                    end else if (last_i) begin
                        r_state <= S_DECIDE;
                    end else begin
                        r_i     <= r_i + 1'b1;
                        r_state <= S_SCAN_RD;
                    end
                end
                S_DECIDE: begin
                    if (room) begin
                        r_res_oc   <= OC_APPENDED;
                        r_res_slot <= AW'(r_count);
                        r_count    <= r_count + 1'b1;
                        r_state    <= S_DONE;
                    end else begin
                        r_i     <= '0;
                        r_j     <= '0;
                        r_at    <= '0;
                        r_own   <= DIST_INF;
                        r_nn    <= DIST_INF;
                        r_mn    <= DIST_INF;
                        r_state <= S_CR_RD;
                    end
                end
                S_CR_RD: r_state <= S_CR_LD;
                S_CR_LD: r_state <= S_CR_WAIT;
                S_CR_WAIT: begin
                    if (dist_done) begin
                        r_own <= n_own;
                        if (last_j) begin
                            // row closed: first entry at the minimum wins
                            if (n_nn < r_mn) begin
                                r_mn <= n_nn;
                                r_at <= r_i;
                            end
                            r_nn <= DIST_INF;
                            r_j  <= '0;
                            if (last_i) begin
                                r_state <= S_CR_END;
                            end else begin
                                r_i     <= r_i + 1'b1;
                                r_state <= S_CR_RD;
                            end
                        end else begin
                            r_nn    <= n_nn;
                            r_j     <= r_j + 1'b1;
                            r_state <= S_CR_RD;
                        end
                    end
                end
                S_CR_END: begin
                    if (crowd_win) begin
                        r_res_oc   <= OC_REPLACED_CROWD;
                        r_res_slot <= r_at;
                    end else begin
                        r_res_oc   <= OC_REJECTED_CROWD;
                        r_res_slot <= '0;
                    end
                    r_state <= S_DONE;
                end
                S_DONE: begin
                    if (out_free) r_state <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    // input capture and result register: payload, no reset
    always_ff @(posedge i_clk) begin
        if (r_state == S_IDLE && take) begin
            r_tag <= s_axis_tdata[TAG_W-1:0];
            r_v   <= s_axis_tdata[TAG_W +: MAX_OBJECTIVES*OBJ_W];
        end
        if (r_state == S_DONE && out_free) begin
            r_out_data <= {OCC_W'(r_count), SLOT_W'(r_res_slot), r_res_oc};
        end
    end

    assign s_axis_tready = (r_state == S_IDLE);
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;

`ifndef NO_ASSERTIONS
    a_state_onehot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot(r_state))
        else $error("state register not one-hot");
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(ARCHIVE_DEPTH))
        else $error("entry count above archive depth");
    a_dist_when_waiting: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        dist_done |-> r_state == S_CR_WAIT)
        else $error("distance result outside crowding wait");
    a_append_counts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DECIDE && room) |=> r_count == $past(r_count) + CW'(1))
        else $error("append did not raise the count");
`endif
endmodule
`default_nettype wire

// ----- test/pareto_archive_insert_core_test.sv -----
// Testbench for pareto_archive_insert_core: offer and maxima items go in on the slave stream,
// each result is checked against a built-in archive predictor. Needs pa_pkg and the RTL.
`timescale 1ns / 1ps
module pareto_archive_insert_core_test;
    import pa_pkg::*;

    localparam int DEPTH     = 64;
    localparam int NOBJ_MAX  = 4;
    localparam int IDLE_LIMIT = 400000;   // watchdog bound: a full 64-entry crowding run plus stalls stays below it

    typedef logic [NOBJ_MAX-1:0][OBJ_W-1:0] t_vec;   // lane k at bits [32k+31:32k]

    typedef struct {
        t_outcome          outcome;
        logic [SLOT_W-1:0] slot;
        logic [OCC_W-1:0]  occ;
    } t_archive_result;

    logic               i_clk;
    logic               i_rst_n;
    logic               s_axis_tvalid;
    logic               s_axis_tready;
    logic [143:0]       s_axis_tdata;   // entry_tag, obj_0, obj_1, obj_2, obj_3
    logic               s_axis_tuser;   // kind
    logic               m_axis_tvalid;
    logic               m_axis_tready = 1'b0;
    logic [15:0]        m_axis_tdata;   // outcome, slot, occupancy
    logic               i_cfg_we;
    logic               i_cfg_addr;
    logic [CAP_W-1:0]   i_cfg_wdata;

    pareto_archive_insert_core u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_addr    (i_cfg_addr),
        .i_cfg_wdata   (i_cfg_wdata)
    );

    always begin
        i_clk = 1'b0; #4;
        i_clk = 1'b1; #4;
    end

    // ---------------------------------------------------------------
    // Archive predictor: own copy of entries, maxima and registers
    // ---------------------------------------------------------------
    t_vec              arch_obj [DEPTH];
    logic [TAG_W-1:0]  arch_tag [DEPTH];
    int                arch_count;
    longint            obj_max  [NOBJ_MAX];
    logic [NOBJ_W-1:0] reg_nobj;
    logic [CAP_W-1:0]  reg_cap;

    t_archive_result   pending_results[$];
    int                mismatch_count;

    function automatic int used_objectives();
        int n;
        n = int'(reg_nobj);
        if (n < 1) n = 1;
        if (n > NOBJ_MAX) n = NOBJ_MAX;
        return n;
    endfunction

    function automatic int held_capacity();
        int c;
        c = int'(reg_cap);
        if (c < 1) c = 1;
        if (c > DEPTH) c = DEPTH;
        return c;
    endfunction

    function automatic bit dominates(t_vec a, t_vec b, int n);
        bit strict;
        strict = 1'b0;
        for (int k = 0; k < n; k++) begin
            if ($signed(a[k]) > $signed(b[k])) return 1'b0;
            if (a[k] != b[k]) strict = 1'b1;
        end
        return strict;
    endfunction

    // Normalized squared distance: per lane floor(|d|*256/max) saturated to 16 bits, squared
    function automatic logic [63:0] norm_dist(t_vec a, t_vec b, int n);
        logic [63:0] sum, ad, dv, r;
        longint      d;
        sum = 0;
        for (int k = 0; k < n; k++) begin
            d  = longint'($signed(a[k])) - longint'($signed(b[k]));
            ad = (d < 0) ? -d : d;
            dv = (obj_max[k] < 1) ? 64'd1 : obj_max[k];
            r  = (ad << 8) / dv;
            if (r > 65535) r = 65535;
            sum += r * r;
        end
        return sum;
    endfunction

    task automatic predict_item(input bit kind, input logic [TAG_W-1:0] tag, input t_vec v);
        t_archive_result res;
        logic [63:0]     nearest [DEPTH];
        logic [63:0]     own, mn, d;
        int              n, at;
        bit              done;
        n = used_objectives();
        res.slot = '0;
        if (kind) begin
            for (int k = 0; k < n; k++)
                if (longint'($signed(v[k])) > obj_max[k]) obj_max[k] = $signed(v[k]);
            res.outcome = OC_MAXIMA;
        end else begin
            done = 1'b0;
            res.outcome = OC_REPLACED_DOM;
            for (int i = 0; i < arch_count && !done; i++) begin
                if (dominates(v, arch_obj[i], n)) begin
                    arch_obj[i] = v; arch_tag[i] = tag;
                    res.outcome = OC_REPLACED_DOM; res.slot = SLOT_W'(i); done = 1'b1;
                end else if (dominates(arch_obj[i], v, n)) begin
                    res.outcome = OC_REJECTED_DOM; res.slot = SLOT_W'(i); done = 1'b1;
                end
            end
            if (!done && arch_count < held_capacity()) begin
                res.slot = SLOT_W'(arch_count);
                arch_obj[arch_count] = v; arch_tag[arch_count] = tag;
                arch_count++;
                res.outcome = OC_APPENDED;
            end else if (!done) begin
                // full: most crowded entry goes only if the offer is less crowded
                own = {28'd0, DIST_INF};
                at  = 0;
                for (int i = 0; i < arch_count; i++) nearest[i] = {28'd0, DIST_INF};
                for (int i = 0; i < arch_count; i++) begin
                    d = norm_dist(v, arch_obj[i], n);
                    if (d < own) own = d;
                    for (int j = i + 1; j < arch_count; j++) begin
                        d = norm_dist(arch_obj[j], arch_obj[i], n);
                        if (d < nearest[i]) nearest[i] = d;
                        if (d < nearest[j]) nearest[j] = d;
                    end
                end
                mn = nearest[0];
                for (int i = 1; i < arch_count; i++)
                    if (nearest[i] < mn) begin
                        mn = nearest[i]; at = i;
                    end
                if (own > mn) begin
                    arch_obj[at] = v; arch_tag[at] = tag;
                    res.outcome = OC_REPLACED_CROWD; res.slot = SLOT_W'(at);
                end else begin
                    res.outcome = OC_REJECTED_CROWD;
                end
            end
        end
        res.occ = OCC_W'(arch_count);
        pending_results.push_back(res);
    endtask

    // ---------------------------------------------------------------
    // Sender: bursts of random length, random gaps in between
    // ---------------------------------------------------------------
    int burst_left;

    task automatic send_item(input bit kind, input logic [TAG_W-1:0] tag, input t_vec v);
        if (burst_left == 0) begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge i_clk);
            // some bursts are long, so stretches without gaps happen too
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(10, 30)
                                                      : $urandom_range(1, 4);
        end
        burst_left--;
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= kind;
        s_axis_tdata  <= {v[3], v[2], v[1], v[0], tag};
        do @(posedge i_clk); while (!s_axis_tready);
        predict_item(kind, tag, v);
    endtask

    task automatic go_idle();
        s_axis_tvalid <= 1'b0;
        burst_left = 0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    // register write, only while idle
    task automatic write_reg(input logic addr, input logic [CAP_W-1:0] value);
        @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_addr  <= addr;
        i_cfg_wdata <= value;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        if (addr == CFG_OBJECTIVES) reg_nobj = value[NOBJ_W-1:0];
        else                        reg_cap  = value;
    endtask

    task automatic configure(input int nobj, input int capacity);
        go_idle();
        write_reg(CFG_OBJECTIVES, CAP_W'(nobj));
        write_reg(CFG_CAPACITY, CAP_W'(capacity));
    endtask

    function automatic t_vec vec2(input logic [31:0] a, input logic [31:0] b);
        t_vec v;
        v = {$urandom(), $urandom(), b, a};
        return v;
    endfunction

    // ---------------------------------------------------------------
    // Receiver stall pattern and result checking
    // ---------------------------------------------------------------
    int rx_phase = 0;
    bit rx_choppy = 1'b0;

    always @(posedge i_clk) begin
        if (rx_phase == 0) begin
            rx_phase  <= $urandom_range(20, 120);
            rx_choppy <= $urandom_range(0, 1);
        end else begin
            rx_phase <= rx_phase - 1;
        end
        // choppy: ready at random, with a chance of 3 in 8; otherwise always ready
        m_axis_tready <= rx_choppy ? ($urandom_range(0, 7) < 3) : 1'b1;
    end

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("mismatch %s: got %0d, expected %0d", what, got, want);
        mismatch_count++;
    endtask

    always @(posedge i_clk) begin
        t_archive_result want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (pending_results.size() == 0) begin
                report_mismatch("unexpected result", m_axis_tdata, -1);
            end else begin
                want = pending_results.pop_front();
                if (m_axis_tdata[2:0] != want.outcome)
                    report_mismatch("outcome", m_axis_tdata[2:0], want.outcome);
                if (m_axis_tdata[8:3] != want.slot)
                    report_mismatch("slot", m_axis_tdata[8:3], want.slot);
                if (m_axis_tdata[15:9] != want.occ)
                    report_mismatch("occupancy", m_axis_tdata[15:9], want.occ);
            end
        end
    end

    // watchdog: cycles with no item moving on either side
    int idle_cycles = 0;
    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    // ---------------------------------------------------------------
    // Tests
    // ---------------------------------------------------------------
    // lone entry in a full archive keeps an infinite nearest distance
    task automatic test_single_entry();
        configure(2, 1);
        send_item(1'b1, 16'h0000, vec2(32'hFFFF_FFFF, 32'h8000_0000)); // negative: no raise
        send_item(1'b1, 16'hFFFF, vec2(32'h0001_0000, 32'h0001_0000));
        send_item(1'b0, 16'hA5A5, vec2(32'h0001_0000, 32'h0001_0000));
        send_item(1'b0, 16'h5A5A, vec2(32'h0000_8000, 32'h0002_0000));
    endtask

    task automatic test_dominance();
        configure(2, 64);
        send_item(1'b0, 16'h0001, vec2(32'h0002_0000, 32'h0002_0000)); // rejected by slot 0
        send_item(1'b0, 16'h0002, vec2(32'h0000_8000, 32'h0000_8000)); // replaces slot 0
        send_item(1'b0, 16'h0003, vec2(32'h0000_8000, 32'h0000_8000)); // equal: appended
        send_item(1'b0, 16'hFFFF, vec2(32'h7FFF_FFFF, 32'h8000_0000));
        send_item(1'b0, 16'h0000, vec2(32'h8000_0000, 32'h7FFF_FFFF));
        send_item(1'b1, 16'h1234, {32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h0010_0000, 32'h0010_0000});
    endtask

    // capacity at and below occupancy: crowding decides
    task automatic test_crowding();
        configure(2, 4);
        send_item(1'b0, 16'h0010, vec2(32'h4000_0000, 32'h8000_0001));
        send_item(1'b0, 16'h0011, vec2(32'h0000_4000, 32'h0000_C000));
        send_item(1'b0, 16'h0012, vec2(32'h0000_6000, 32'h0000_A000));
        configure(2, 2);   // below occupancy, nothing dropped
        send_item(1'b0, 16'h0013, vec2(32'h0000_7000, 32'h0000_9000));
        send_item(1'b0, 16'h0014, vec2(32'h2000_0000, 32'h8000_0002));
    endtask

    // out-of-range register values are clamped
    task automatic test_register_range();
        configure(0, 0);
        send_item(1'b1, 16'h0020, {32'h0100_0000, 32'h0100_0000, 32'h0100_0000, 32'h0100_0000});
        send_item(1'b0, 16'h0021, vec2(32'h0000_7800, 32'h0000_0000));
        configure(7, 4);
        send_item(1'b1, 16'h0022, {32'h0100_0000, 32'h0100_0000, 32'h0100_0000, 32'h0100_0000});
        send_item(1'b0, 16'h0023, {32'h8000_0000, 32'h7FFF_FFFF, 32'h0000_7000, 32'h0000_9000});
    endtask

    task automatic random_phase(input int nobj, input int capacity, input int count);
        t_vec v;
        configure(nobj, capacity);
        for (int i = 0; i < count; i++) begin
            for (int k = 0; k < NOBJ_MAX; k++)
                v[k] = ($urandom_range(0, 6) == 0) ? $urandom()
                       : 32'($urandom_range(0, 32'h3_FFFF)) - 32'h2_0000;
            if ($urandom_range(0, 9) == 0) begin
                for (int k = 0; k < NOBJ_MAX; k++)
                    if ($urandom_range(0, 1)) v[k] = $urandom_range(0, 32'h0100_0000);
                send_item(1'b1, TAG_W'($urandom()), v);
            end else begin
                send_item(1'b0, TAG_W'($urandom()), v);
            end
        end
    endtask

    // mutually incomparable points along a diagonal fill all 64 slots
    task automatic test_full_archive();
        configure(2, 127);
        for (int i = 0; i < 70; i++)
            send_item(1'b0, TAG_W'($urandom()),
                      vec2(32'h8000_0000 + 32'(3 * i), 32'h8000_0000 + 32'(300 - 3 * i)));
        for (int i = 0; i < 3; i++)
            send_item(1'b0, TAG_W'($urandom()), vec2(32'h8000_0000 + 32'(20 * i + 1),
                                                      32'h8000_0000 + 32'(300 - 20 * i - 1)));
        configure(2, 64);
    endtask

    initial begin
        i_rst_n       <= 1'b0;
        s_axis_tvalid <= 1'b0;
        s_axis_tuser  <= 1'b0;
        s_axis_tdata  <= '0;
        i_cfg_we      <= 1'b0;
        i_cfg_addr    <= 1'b0;
        i_cfg_wdata   <= '0;
        burst_left     = 0;
        mismatch_count = 0;
        arch_count     = 0;
        reg_nobj       = 3'd2;
        reg_cap        = 7'd64;
        for (int k = 0; k < NOBJ_MAX; k++) obj_max[k] = 0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_single_entry();
        test_dominance();
        test_crowding();
        test_register_range();
        random_phase(1, 6, 10);
        random_phase(2, 3, 10);
        random_phase(3, 8, 10);
        random_phase(4, 12, 10);
        random_phase(2, 10, 8);
        test_full_archive();

        go_idle();
        repeat (20) @(posedge i_clk);
        if (mismatch_count == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end
endmodule
